[rtl/core/dmhq_pkg.sv]
`timescale 1ns / 1ps
// dmhq_pkg: types, sizes and codes for the deadline min-heap queue
// no dependencies

package dmhq_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int TIME_W      = 64;
   localparam int ID_W        = 10;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 11;
   localparam int SLOT_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int CHILD_W     = SLOT_W + 2;

   localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   entry_id;
      logic [63:0]       deadline;
      logic [63:0]       delay_increment;
      logic [63:0]       now_time;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ID_W-1:0]        popped_id;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] key;
   } heap_word_type;

   typedef struct packed {
      logic              present;
      logic [SLOT_W-1:0] slot;
   } entry_word_type;

   localparam int HEAP_WORD_W  = $bits(heap_word_type);
   localparam int ENTRY_WORD_W = $bits(entry_word_type);

endpackage

[rtl/core/dmhq_ram.sv]
`timescale 1ns / 1ps
// dmhq_ram: generic single-write, single-read ram with registered read
// no dependencies

module dmhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/deadline_min_heap_queue_unit.sv]
`timescale 1ns / 1ps
// deadline_min_heap_queue_unit: indexed min-heap of ids keyed by deadlines
// depends on dmhq_pkg and dmhq_ram

// One word at a time: a word is taken when start is high and busy is low,
// and its single result appears for one cycle with rsp_valid, which the
// receiver cannot stall. After reset the block clears all MAX_ENTRIES (1024)
// words of the per-id table with busy high. An error or a pop with nothing
// due returns without walking the heap; add, remove, advance and a due pop
// walk it one level at a time, since the slot-indexed heap memory has one
// read port.
module deadline_min_heap_queue_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dmhq_pkg::req_type req_data,
   output logic             rsp_valid,
   output dmhq_pkg::rsp_type rsp_data
);
   import dmhq_pkg::*;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_LOOK   = 4'd2;
   localparam logic [3:0] ST_LAST   = 4'd3;
   localparam logic [3:0] ST_KEY    = 4'd4;
   localparam logic [3:0] ST_UP_RD  = 4'd5;
   localparam logic [3:0] ST_UP_CMP = 4'd6;
   localparam logic [3:0] ST_DN_RDL = 4'd7;
   localparam logic [3:0] ST_DN_RDR = 4'd8;
   localparam logic [3:0] ST_DN_CMP = 4'd9;
   localparam logic [3:0] ST_PLACE  = 4'd10;
   localparam logic [3:0] ST_DONE   = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [63:0]         arg_ff, arg_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   heap_word_type       cur_ff, cur_in;
   heap_word_type       left_ff, left_in;
   logic                moved_ff, moved_in;
   logic                right_ok_ff, right_ok_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     popped_ff, popped_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                h_wr_en, h_rd_en;
   logic [SLOT_W-1:0]   h_wr_addr, h_rd_addr;
   heap_word_type       h_wr_data, h_rd_data;
   logic                e_wr_en, e_rd_en;
   logic [SLOT_W-1:0]   e_wr_addr, e_rd_addr;
   entry_word_type      e_wr_data, e_rd_data;

   logic [COUNT_W-1:0]  cnt_dec;
   logic [CHILD_W-1:0]  lidx, ridx;
   logic [SLOT_W-1:0]   parent;
   logic                in_range;
   logic                left_lt, right_lt;
   logic [TIME_W-1:0]   best_key;

   dmhq_ram #(.WIDTH(HEAP_WORD_W), .DEPTH(MAX_ENTRIES)) u_heap_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   dmhq_ram #(.WIDTH(ENTRY_WORD_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data),
      .rd_en   (e_rd_en),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data)
   );

   assign cnt_dec  = cnt_ff - COUNT_W'(1);
   assign lidx     = (CHILD_W'(slot_ff) << 1) + CHILD_W'(1);
   assign ridx     = lidx + CHILD_W'(1);
   assign parent   = (slot_ff - SLOT_W'(1)) >> 1;
   assign in_range = 32'(req_data.entry_id) < 32'(MAX_ENTRIES);
   assign left_lt  = left_ff.key < cur_ff.key;
   assign best_key = left_lt ? left_ff.key : cur_ff.key;
   assign right_lt = right_ok_ff && (h_rd_data.key < best_key);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      arg_in       = arg_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      moved_in     = moved_ff;
      right_ok_in  = right_ok_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      h_wr_en      = 1'b0;
      h_wr_addr    = slot_ff;
      h_wr_data    = cur_ff;
      h_rd_en      = 1'b0;
      h_rd_addr    = '0;
      e_wr_en      = 1'b0;
      e_wr_addr    = '0;
      e_wr_data    = '0;
      e_rd_en      = 1'b0;
      e_rd_addr    = SLOT_W'(req_data.entry_id);

      unique case (state_ff)
         ST_CLEAR: begin
            e_wr_en   = 1'b1;
            e_wr_addr = clr_ff;
            clr_in    = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(MAX_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               func_in   = req_data.func;
               id_in     = req_data.entry_id;
               status_in = STATUS_OK;
               popped_in = '0;
               unique case (req_data.func)
                  FUNC_ADD:     arg_in = req_data.deadline;
                  FUNC_ADVANCE: arg_in = req_data.delay_increment;
                  FUNC_POP:     arg_in = req_data.now_time;
                  default:      arg_in = req_data.deadline;
               endcase
               if (req_data.func == FUNC_POP) begin
                  if (cnt_ff == '0) begin
                     status_in = STATUS_NONE;
                     state_in  = ST_DONE;
                  end else begin
                     h_rd_en   = 1'b1;
                     h_rd_addr = '0;
                     state_in  = ST_LOOK;
                  end
               end else if (!in_range) begin
                  status_in = STATUS_ABSENT;
                  state_in  = ST_DONE;
               end else begin
                  e_rd_en  = 1'b1;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            unique case (func_ff)
               FUNC_ADD: begin
                  if (e_rd_data.present) begin
                     status_in = STATUS_PRESENT;
                     state_in  = ST_DONE;
                  end else if (cnt_ff >= COUNT_W'(MAX_ENTRIES)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     cur_in.id  = id_ff;
                     cur_in.key = arg_ff[TIME_W-1:0];
                     slot_in    = SLOT_W'(cnt_ff);
                     cnt_in     = cnt_ff + COUNT_W'(1);
                     state_in   = ST_UP_RD;
                  end
               end
               FUNC_REMOVE: begin
                  if (!e_rd_data.present) begin
                     status_in = STATUS_ABSENT;
                     state_in  = ST_DONE;
                  end else begin
                     e_wr_en   = 1'b1;
                     e_wr_addr = SLOT_W'(id_ff);
                     cnt_in    = cnt_dec;
                     slot_in   = e_rd_data.slot;
                     if (COUNT_W'(e_rd_data.slot) < cnt_dec) begin
                        h_rd_en   = 1'b1;
                        h_rd_addr = SLOT_W'(cnt_dec);
                        state_in  = ST_LAST;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               end
               FUNC_ADVANCE: begin
                  if (!e_rd_data.present) begin
                     status_in = STATUS_ABSENT;
                     state_in  = ST_DONE;
                  end else begin
                     h_rd_en   = 1'b1;
                     h_rd_addr = e_rd_data.slot;
                     slot_in   = e_rd_data.slot;
                     state_in  = ST_KEY;
                  end
               end
               default: begin
                  if (h_rd_data.key > arg_ff[TIME_W-1:0]) begin
                     status_in = STATUS_NONE;
                     state_in  = ST_DONE;
                  end else begin
                     popped_in = h_rd_data.id;
                     e_wr_en   = 1'b1;
                     e_wr_addr = SLOT_W'(h_rd_data.id);
                     cnt_in    = cnt_dec;
                     slot_in   = '0;
                     if (cnt_dec != '0) begin
                        h_rd_en   = 1'b1;
                        h_rd_addr = SLOT_W'(cnt_dec);
                        state_in  = ST_LAST;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               end
            endcase
         end
         ST_LAST: begin
            cur_in   = h_rd_data;
            moved_in = 1'b0;
            state_in = ST_DN_RDL;
         end
         ST_KEY: begin
            cur_in.id  = id_ff;
            cur_in.key = h_rd_data.key + arg_ff[TIME_W-1:0];
            moved_in   = 1'b0;
            state_in   = ST_DN_RDL;
         end
         ST_UP_RD: begin
            if (slot_ff == '0) begin
               state_in = ST_PLACE;
            end else begin
               h_rd_en   = 1'b1;
               h_rd_addr = parent;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (cur_ff.key < h_rd_data.key) begin
               h_wr_en        = 1'b1;
               h_wr_data      = h_rd_data;
               e_wr_en        = 1'b1;
               e_wr_addr      = SLOT_W'(h_rd_data.id);
               e_wr_data.present = 1'b1;
               e_wr_data.slot = slot_ff;
               slot_in        = parent;
               state_in       = ST_UP_RD;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_DN_RDL: begin
            if (lidx >= CHILD_W'(cnt_ff)) begin
               state_in = moved_ff ? ST_PLACE : ST_UP_RD;
            end else begin
               h_rd_en   = 1'b1;
               h_rd_addr = lidx[SLOT_W-1:0];
               state_in  = ST_DN_RDR;
            end
         end
         ST_DN_RDR: begin
            left_in = h_rd_data;
            if (ridx < CHILD_W'(cnt_ff)) begin
               h_rd_en     = 1'b1;
               h_rd_addr   = ridx[SLOT_W-1:0];
               right_ok_in = 1'b1;
            end else begin
               right_ok_in = 1'b0;
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (right_lt || left_lt) begin
               h_wr_en           = 1'b1;
               h_wr_data         = right_lt ? h_rd_data : left_ff;
               e_wr_en           = 1'b1;
               e_wr_addr         = SLOT_W'(h_wr_data.id);
               e_wr_data.present = 1'b1;
               e_wr_data.slot    = slot_ff;
               slot_in           = right_lt ? ridx[SLOT_W-1:0] : lidx[SLOT_W-1:0];
               moved_in          = 1'b1;
               state_in          = ST_DN_RDL;
            end else begin
               state_in = moved_ff ? ST_PLACE : ST_UP_RD;
            end
         end
         ST_PLACE: begin
            h_wr_en           = 1'b1;
            e_wr_en           = 1'b1;
            e_wr_addr         = SLOT_W'(cur_ff.id);
            e_wr_data.present = 1'b1;
            e_wr_data.slot    = slot_ff;
            state_in          = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.status      = status_ff;
            rsp_data_in.popped_id   = popped_ff;
            rsp_data_in.entry_count = COUNT_OUT_W'(cnt_ff);
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      id_ff       <= id_in;
      arg_ff      <= arg_in;
      slot_ff     <= slot_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      moved_ff    <= moved_in;
      right_ok_ff <= right_ok_in;
      status_ff   <= status_in;
      popped_ff   <= popped_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/dmhq_checker.sv]
`timescale 1ns / 1ps
// dmhq_checker: port-level assertions for the deadline min-heap queue
// depends on dmhq_pkg; bound to deadline_min_heap_queue_unit below

module dmhq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input dmhq_pkg::req_type req_data,
   input logic              rsp_valid,
   input dmhq_pkg::rsp_type rsp_data
);
   import dmhq_pkg::*;

   logic unused_req;
   assign unused_req = ^req_data;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in adjacent cycles");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= COUNT_OUT_W'(MAX_ENTRIES))
      else $error("entry count beyond capacity");

   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.popped_id == '0)
      else $error("popped id set on a failed word");

endmodule

bind deadline_min_heap_queue_unit dmhq_checker u_dmhq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
